@@ rtl/core/peq_pkg.sv @@
package peq_pkg;

  // Sizing
  localparam int QUEUE_DEPTH = 16;
  localparam int USER_QUEUES = 3;
  localparam int NUM_Q       = 4;
  localparam int HOST_Q      = 3;
  localparam int HOST_LEN_RST = 16;

  localparam int LEN_W     = 5;
  localparam int SLOT_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int MEM_DEPTH = NUM_Q * QUEUE_DEPTH;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam int Q_W       = 2;
  localparam int CFG_IDX_W = 2;
  localparam int WORD_W    = 32;
  localparam int FUNC_W    = 2;
  localparam int SEL_W     = 3;
  localparam int STATUS_W  = 3;

  // Function codes
  localparam logic [FUNC_W-1:0] FUNC_USER = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_HOST = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_SVC  = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_ACCEPT  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOINIT  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EVENT   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd5;

  // Controller -> datapath
  typedef struct packed {
    logic load_item;
    logic dec;
    logic mod_post;
    logic mod_svc;
    logic mod_step;
    logic post_write;
    logic svc_load;
    logic mem_rd;
    logic out_event;
    logic out_result;
    logic out_empty;
    logic q_finish;
    logic cur_dec;
  } peq_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              post_ok;
    logic              mod_ge;
    logic              q_active;
    logic              remain_zero;
    logic              cur_zero;
    logic              any_evt;
    logic              out_free;
  } peq_stat_t;

  // Programmed length saturated to the physical depth
  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] l);
    return (l > LEN_W'(QUEUE_DEPTH)) ? LEN_W'(QUEUE_DEPTH) : l;
  endfunction

endpackage

@@ rtl/core/peq_ctrl.sv @@
module peq_ctrl
  import peq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  peq_stat_t stat_i,
  output peq_cmd_t  cmd_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DEC   = 4'd1;
  localparam logic [3:0] S_PMOD  = 4'd2;
  localparam logic [3:0] S_RES   = 4'd3;
  localparam logic [3:0] S_QSEL  = 4'd4;
  localparam logic [3:0] S_SMOD  = 4'd5;
  localparam logic [3:0] S_SRD   = 4'd6;
  localparam logic [3:0] S_SEM   = 4'd7;
  localparam logic [3:0] S_NEXT  = 4'd8;
  localparam logic [3:0] S_EMPTY = 4'd9;

  logic [3:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d = S_DEC;
        end
      end
      S_DEC: begin
        cmd_o.dec = 1'b1;
        case (stat_i.func)
          FUNC_SVC:  state_d = S_QSEL;
          FUNC_NONE: state_d = S_IDLE;
          default: begin
            if (stat_i.post_ok) begin
              cmd_o.mod_post = 1'b1;
              state_d = S_PMOD;
            end else begin
              state_d = S_RES;
            end
          end
        endcase
      end
      S_PMOD: begin
        if (stat_i.mod_ge) begin
          cmd_o.mod_step = 1'b1;
        end else begin
          cmd_o.post_write = 1'b1;
          state_d = S_RES;
        end
      end
      S_RES: begin
        if (stat_i.out_free) begin
          cmd_o.out_result = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_QSEL: begin
        if (stat_i.q_active) begin
          cmd_o.mod_svc = 1'b1;
          state_d = S_SMOD;
        end else begin
          state_d = S_NEXT;
        end
      end
      S_SMOD: begin
        if (stat_i.mod_ge) begin
          cmd_o.mod_step = 1'b1;
        end else begin
          cmd_o.svc_load = 1'b1;
          state_d = S_SRD;
        end
      end
      S_SRD: begin
        if (stat_i.remain_zero) begin
          cmd_o.q_finish = 1'b1;
          state_d = S_NEXT;
        end else begin
          cmd_o.mem_rd = 1'b1;
          state_d = S_SEM;
        end
      end
      S_SEM: begin
        if (stat_i.out_free) begin
          cmd_o.out_event = 1'b1;
          state_d = S_SRD;
        end
      end
      S_NEXT: begin
        if (stat_i.cur_zero) begin
          state_d = stat_i.any_evt ? S_IDLE : S_EMPTY;
        end else begin
          cmd_o.cur_dec = 1'b1;
          state_d = S_QSEL;
        end
      end
      S_EMPTY: begin
        if (stat_i.out_free) begin
          cmd_o.out_empty = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ rtl/core/peq_datapath.sv @@
module peq_datapath
  import peq_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [FUNC_W-1:0]    func_i,
  input  logic [SEL_W-1:0]     queue_sel_i,
  input  logic [WORD_W-1:0]    sig_i,
  input  logic [WORD_W-1:0]    par_i,
  input  logic                 cfg_valid_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [LEN_W-1:0]     cfg_data_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic [STATUS_W-1:0]  status_o,
  output logic [Q_W-1:0]       event_prio_o,
  output logic [WORD_W-1:0]    event_sig_o,
  output logic [WORD_W-1:0]    event_par_o,
  output logic                 last_o,
  input  peq_cmd_t             cmd_i,
  output peq_stat_t            stat_o
);

  // Config and per-queue ring state
  logic [LEN_W-1:0]  len_q  [NUM_Q];
  logic [SLOT_W-1:0] rptr_q [NUM_Q];
  logic [LEN_W-1:0]  cnt_q  [NUM_Q];

  // Captured item
  logic [FUNC_W-1:0] func_q;
  logic [SEL_W-1:0]  sel_q;
  logic [WORD_W-1:0] sig_q;
  logic [WORD_W-1:0] par_q;

  // Working registers
  logic [Q_W-1:0]      cur_q;
  logic [LEN_W-1:0]    mod_q;
  logic [SLOT_W-1:0]   rd_q;
  logic [LEN_W-1:0]    remain_q;
  logic                any_q;
  logic [STATUS_W-1:0] code_q;

  // Event store
  logic [2*WORD_W-1:0] store_q [MEM_DEPTH];
  logic [2*WORD_W-1:0] rdata_q;

  // Output register
  logic                out_valid_q;
  logic [STATUS_W-1:0] out_status_q;
  logic [Q_W-1:0]      out_prio_q;
  logic [WORD_W-1:0]   out_sig_q;
  logic [WORD_W-1:0]   out_par_q;
  logic                out_last_q;

  logic                is_host;
  logic [Q_W-1:0]      post_q;
  logic [LEN_W-1:0]    post_len;
  logic [STATUS_W-1:0] post_code;
  logic [LEN_W-1:0]    cur_len;
  logic                lower_pending;
  logic                out_free;
  logic [LEN_W-1:0]    rd_inc;
  logic [ADDR_W-1:0]   cur_addr_wr;
  logic [ADDR_W-1:0]   cur_addr_rd;

  function automatic logic [ADDR_W-1:0] slot_addr(input logic [Q_W-1:0] q,
                                                  input logic [SLOT_W-1:0] s);
    return ADDR_W'(ADDR_W'(q) * ADDR_W'(QUEUE_DEPTH)) + ADDR_W'(s);
  endfunction

  // Post checks on the captured item
  always_comb begin
    is_host  = (func_q == FUNC_HOST);
    post_q   = is_host ? Q_W'(HOST_Q) : sel_q[Q_W-1:0];
    post_len = eff_len(len_q[post_q]);
    if (!is_host && (sel_q >= SEL_W'(USER_QUEUES))) begin
      post_code = ST_INVALID;
    end else if (!is_host && (post_len == '0)) begin
      post_code = ST_NOINIT;
    end else if (cnt_q[post_q] >= post_len) begin
      post_code = ST_FULL;
    end else begin
      post_code = ST_ACCEPT;
    end
  end

  assign cur_len  = eff_len(len_q[cur_q]);
  assign out_free = !out_valid_q || out_ready_i;
  assign rd_inc   = LEN_W'(rd_q) + LEN_W'(1);
  assign cur_addr_wr = slot_addr(cur_q, mod_q[SLOT_W-1:0]);
  assign cur_addr_rd = slot_addr(cur_q, rd_q);

  // Events still waiting in queues below the one being drained
  always_comb begin
    lower_pending = 1'b0;
    for (int j = 0; j < NUM_Q; j++) begin
      if ((Q_W'(j) < cur_q) && ((j == HOST_Q) || (j < USER_QUEUES)) &&
          (eff_len(len_q[j]) != '0) && (cnt_q[j] != '0)) begin
        lower_pending = 1'b1;
      end
    end
  end

  always_comb begin
    stat_o.func        = func_q;
    stat_o.post_ok     = (post_code == ST_ACCEPT);
    stat_o.mod_ge      = (mod_q >= cur_len);
    stat_o.q_active    = ((cur_q == Q_W'(HOST_Q)) || (cur_q < Q_W'(USER_QUEUES))) &&
                         (cur_len != '0);
    stat_o.remain_zero = (remain_q == '0);
    stat_o.cur_zero    = (cur_q == '0);
    stat_o.any_evt     = any_q;
    stat_o.out_free    = out_free;
  end

  // Lengths, pointers, counts
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < NUM_Q; j++) begin
        len_q[j]  <= (j == HOST_Q) ? LEN_W'(HOST_LEN_RST) : '0;
        rptr_q[j] <= '0;
        cnt_q[j]  <= '0;
      end
    end else begin
      if (cfg_valid_i) begin
        len_q[cfg_index_i] <= cfg_data_i;
      end
      if (cmd_i.post_write) begin
        cnt_q[cur_q] <= cnt_q[cur_q] + LEN_W'(1);
      end
      if (cmd_i.q_finish) begin
        rptr_q[cur_q] <= rd_q;
        cnt_q[cur_q]  <= '0;
      end
    end
  end

  // Sequencing registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q    <= '0;
      mod_q    <= '0;
      rd_q     <= '0;
      remain_q <= '0;
      any_q    <= 1'b0;
      code_q   <= ST_ACCEPT;
    end else begin
      if (cmd_i.dec) begin
        code_q <= post_code;
        any_q  <= 1'b0;
        cur_q  <= (func_q == FUNC_SVC) ? Q_W'(HOST_Q) : post_q;
      end
      if (cmd_i.cur_dec) begin
        cur_q <= cur_q - Q_W'(1);
      end
      // Modulo by the queue length: repeated subtract
      if (cmd_i.mod_post) begin
        mod_q <= LEN_W'(rptr_q[post_q]) + cnt_q[post_q];
      end
      if (cmd_i.mod_svc) begin
        mod_q <= LEN_W'(rptr_q[cur_q]);
      end
      if (cmd_i.mod_step) begin
        mod_q <= mod_q - cur_len;
      end
      if (cmd_i.svc_load) begin
        rd_q     <= mod_q[SLOT_W-1:0];
        remain_q <= cnt_q[cur_q];
      end
      if (cmd_i.out_event) begin
        rd_q     <= (rd_inc == cur_len) ? '0 : rd_inc[SLOT_W-1:0];
        remain_q <= remain_q - LEN_W'(1);
        any_q    <= 1'b1;
      end
    end
  end

  // Item capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      func_q <= func_i;
      sel_q  <= queue_sel_i;
      sig_q  <= sig_i;
      par_q  <= par_i;
    end
  end

  // Event store, registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.post_write) begin
      store_q[cur_addr_wr] <= {sig_q, par_q};
    end
    if (cmd_i.mem_rd) begin
      rdata_q <= store_q[cur_addr_rd];
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_event || cmd_i.out_result || cmd_i.out_empty) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_event) begin
      out_status_q <= ST_EVENT;
      out_prio_q   <= cur_q;
      out_sig_q    <= rdata_q[2*WORD_W-1:WORD_W];
      out_par_q    <= rdata_q[WORD_W-1:0];
      out_last_q   <= (remain_q == LEN_W'(1)) && !lower_pending;
    end else if (cmd_i.out_result || cmd_i.out_empty) begin
      out_status_q <= cmd_i.out_empty ? ST_EMPTY : code_q;
      out_prio_q   <= '0;
      out_sig_q    <= '0;
      out_par_q    <= '0;
      out_last_q   <= 1'b1;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign event_prio_o = out_prio_q;
  assign event_sig_o  = out_sig_q;
  assign event_par_o  = out_par_q;
  assign last_o       = out_last_q;

  // A store write always lands inside the ring
  a_write_in_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.post_write |-> (mod_q < cur_len) && (cnt_q[cur_q] < cur_len))
    else $error("post write outside ring");

  // An event is only emitted while the drain still has events counted
  a_event_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_event |-> (remain_q != '0) && out_free)
    else $error("event emitted with nothing counted");

  // A drained queue is left empty
  a_finish_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.q_finish |=> (cnt_q[$past(cur_q)] == '0))
    else $error("drained queue count not cleared");

endmodule

@@ rtl/core/priority_event_queues_top.sv @@
// Priority event queues: three user ring-buffer queues (priority 0..2) and
// one host queue at the top priority (reported as priority 3).
// Channels:
//   in  : valid/ready transfer of func, queue_sel, sig, par. func 0 posts to a
//         user queue, 1 posts to the host queue, 2 services all queues,
//         3 is ignored and gives no result.
//   out : valid/ready transfer of status, event_prio, event_sig, event_par,
//         last. A post gives one result; a service gives one result per
//         stored event (host queue first, then priority 2 down to 0, FIFO
//         within a queue) or a single "nothing pending" result; last marks
//         the final one.
//   cfg : valid/ready register write, index 0..2 user lengths, 3 host length.
//         Always ready; write only while the block is idle.
// Sequence: an item is taken only in the idle state. An accepted post is
// decoded, steps the slot modulo by repeated length subtraction, writes the
// store and loads its result; a rejected post loads it after decode. A
// service decodes, then walks the queues: a skipped queue is passed over, an
// initialized queue runs the read pointer modulo and then, per event, a
// registered store read and an output load; a "nothing pending" result
// follows when no event was found. The next item is taken once the
// sequencer is idle again. The output register lets the next item be taken
// while a result waits; a stalled receiver holds the sequencer in its emit
// state, nothing is dropped. Reset: pointers and counts clear, user lengths go
// to 0, host length to 16; the event store itself is not cleared.
module priority_event_queues_top
  import peq_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // item in
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [FUNC_W-1:0]    func_i,
  input  logic [SEL_W-1:0]     queue_sel_i,
  input  logic [WORD_W-1:0]    sig_i,
  input  logic [WORD_W-1:0]    par_i,
  // result out
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [STATUS_W-1:0]  status_o,
  output logic [Q_W-1:0]       event_prio_o,
  output logic [WORD_W-1:0]    event_sig_o,
  output logic [WORD_W-1:0]    event_par_o,
  output logic                 last_o,
  // config write
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [LEN_W-1:0]     cfg_data_i
);

  peq_cmd_t  cmd;
  peq_stat_t stat;

  // Length registers take a write in any cycle
  assign cfg_ready_o = 1'b1;

  // Sequencer: post, modulo, drain walk, output handoff
  peq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Rings, event store, modulo unit and output register
  peq_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .func_i       (func_i),
    .queue_sel_i  (queue_sel_i),
    .sig_i        (sig_i),
    .par_i        (par_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .status_o     (status_o),
    .event_prio_o (event_prio_o),
    .event_sig_o  (event_sig_o),
    .event_par_o  (event_par_o),
    .last_o       (last_o),
    .cmd_i        (cmd),
    .stat_o       (stat)
  );

endmodule
